/* rtl/ktrt_pkg.sv */
// ----------------------------------------------------------------------------
// ktrt_pkg
// Types, sizes and codes shared by the k-mer tandem repeat tracker modules.
// ----------------------------------------------------------------------------
package ktrt_pkg;

  localparam int unsigned MAX_K      = 8;
  localparam int unsigned POS_BITS   = 32;
  localparam int unsigned IDX_W      = 2 * MAX_K;
  localparam int unsigned TBL_DEPTH  = 1 << IDX_W;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned GAP_W      = 32;
  localparam int unsigned K_W        = 4;
  localparam int unsigned MINR_W     = 16;
  localparam int unsigned MAXG_W     = 8;
  localparam int unsigned RUN_W      = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [K_W-1:0]    K_MIN          = K_W'(2);
  localparam logic [K_W-1:0]    K_MAX          = K_W'(MAX_K);
  localparam logic [K_W-1:0]    KMER_LEN_RST   = K_W'(4);
  localparam logic [MINR_W-1:0] MIN_REPEAT_RST = MINR_W'(5);
  localparam logic [MAXG_W-1:0] MAX_GAP_RST    = '0;

  typedef enum logic [1:0] {
    REQ_BASE  = 2'd0,
    REQ_DRAIN = 2'd1,
    REQ_NEW   = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KMER_LEN    = 2'd0,
    CFG_MIN_REPEATS = 2'd1,
    CFG_MAX_GAP     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [2:0]       base_code;
    logic [IDX_W-1:0] drain_index;
  } ktrt_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]    kmer_code;
    logic [CNT_W-1:0]    repeat_count;
    logic [POS_BITS-1:0] start_pos;
    logic [POS_BITS-1:0] end_pos;
    logic [GAP_W-1:0]    gap_total;
    logic                from_drain;
  } ktrt_res_t;

  // one table row: the open repeat block of a k-mer
  typedef struct packed {
    logic                valid;
    logic [POS_BITS-1:0] start_pos;
    logic [POS_BITS-1:0] end_pos;
    logic [CNT_W-1:0]    count;
    logic [GAP_W-1:0]    gaps;
  } ktrt_entry_t;

  // context of the transaction whose row is being read
  typedef struct packed {
    logic                is_drain;
    logic [IDX_W-1:0]    idx;
    logic [POS_BITS-1:0] pos;
    logic [K_W-1:0]      k;
  } ktrt_ctx_t;

  typedef struct packed {
    ktrt_entry_t entry;
    logic        emit;
    ktrt_res_t   res;
  } ktrt_upd_t;

endpackage

/* rtl/ktrt_table.sv */
// ----------------------------------------------------------------------------
// ktrt_table
// Block table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ktrt_table
  import ktrt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output ktrt_entry_t      rd_data_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  ktrt_entry_t      wr_data_i
);

  ktrt_entry_t mem_q [TBL_DEPTH];
  ktrt_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/ktrt_update.sv */
// ----------------------------------------------------------------------------
// ktrt_update
// Modify step: new table row and optional reported block from the row read.
// ----------------------------------------------------------------------------
module ktrt_update
  import ktrt_pkg::*;
(
  input  ktrt_ctx_t         ctx_i,
  input  ktrt_entry_t       entry_i,
  input  logic [MINR_W-1:0] min_repeats_i,
  input  logic [MAXG_W-1:0] max_gap_i,
  output ktrt_upd_t         upd_o
);

  logic [POS_BITS-1:0] delta;
  logic [POS_BITS-1:0] end_new;
  logic [MAXG_W:0]     lim;
  logic                neg;
  logic                near;
  logic                far;
  logic                enough;
  logic [GAP_W:0]      gap_sum;
  ktrt_entry_t         opened;
  ktrt_entry_t         extended;

  always_comb begin
    delta   = ctx_i.pos - entry_i.end_pos;
    end_new = ctx_i.pos + POS_BITS'(ctx_i.k - K_W'(1));
    lim     = {1'b0, max_gap_i} + (MAXG_W + 1)'(1);
    neg     = delta[POS_BITS-1];
    near    = !neg && (delta != '0) && (delta <= POS_BITS'(lim));
    far     = !neg && (delta > POS_BITS'(lim));
    enough  = entry_i.valid && (entry_i.count >= CNT_W'(min_repeats_i));
    gap_sum = {1'b0, entry_i.gaps} + (GAP_W + 1)'(delta - POS_BITS'(1));

    opened.valid     = 1'b1;
    opened.start_pos = ctx_i.pos;
    opened.end_pos   = end_new;
    opened.count     = CNT_W'(1);
    opened.gaps      = '0;

    extended.valid     = 1'b1;
    extended.start_pos = entry_i.start_pos;
    extended.end_pos   = end_new;
    extended.count     = (entry_i.count == '1) ? entry_i.count : entry_i.count + CNT_W'(1);
    extended.gaps      = gap_sum[GAP_W] ? '1 : gap_sum[GAP_W-1:0];

    upd_o.res.kmer_code    = ctx_i.idx;
    upd_o.res.repeat_count = entry_i.count;
    upd_o.res.start_pos    = entry_i.start_pos;
    upd_o.res.end_pos      = entry_i.end_pos;
    upd_o.res.gap_total    = entry_i.gaps;
    upd_o.res.from_drain   = ctx_i.is_drain;

    if (ctx_i.is_drain) begin
      upd_o.entry = '0;
      upd_o.emit  = enough;
    end else if (!entry_i.valid) begin
      upd_o.entry = opened;
      upd_o.emit  = 1'b0;
    end else if (near) begin
      upd_o.entry = extended;
      upd_o.emit  = 1'b0;
    end else if (far) begin
      upd_o.entry = opened;
      upd_o.emit  = enough;
    end else begin
      // overlapping occurrence keeps the row as it is
      upd_o.entry = entry_i;
      upd_o.emit  = 1'b0;
    end
  end

endmodule

/* rtl/kmer_tandem_repeat_tracker.sv */
// ----------------------------------------------------------------------------
// kmer_tandem_repeat_tracker
// Tandem repeat detector over a stream of DNA bases with a 4^MAX_K block table.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction (base, drain, new sequence) is taken on a rising edge with
//   start high and busy low; its fields come on req_i. Configuration is
//   written through cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle.
//   Results leave on res_o, qualified by res_valid_o for one cycle; the
//   receiver cannot stall, and each result is shown exactly once.
// Timing:
//   A base that completes a clean window, and a drain, read the table row on
//   the accept edge, modify and write it back in the next cycle (busy high),
//   and show any result in the cycle after that. Other bases and ignored
//   requests keep the block idle. The rate is set by the single
//   read-modify-write of the table per transaction.
// Reset and new sequence:
//   Both run a clearing pass over the table, one row per cycle, with busy
//   high; the rolling index, position and clean run are zeroed.
// ----------------------------------------------------------------------------
module kmer_tandem_repeat_tracker
  import ktrt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  ktrt_req_t             req_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  res_valid_o,
  output ktrt_res_t             res_o
);

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    clr_q;
  logic [IDX_W-1:0]    roll_q, roll_d;
  logic [RUN_W-1:0]    run_q, run_d;
  logic [POS_BITS-1:0] pos_cnt_q;
  logic [K_W-1:0]      kmer_len_q;
  logic [MINR_W-1:0]   min_repeats_q;
  logic [MAXG_W-1:0]   max_gap_q;
  ktrt_ctx_t           ctx_q, ctx_d;
  logic                res_valid_q;
  ktrt_res_t           res_q;

  logic             accept;
  logic             is_n;
  logic             hit;
  logic [K_W-1:0]   k_eff;
  logic [IDX_W-1:0] kmask;
  logic             do_rmw;

  logic             tbl_re;
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr;
  ktrt_entry_t      tbl_wdata;
  ktrt_entry_t      tbl_rdata;
  ktrt_upd_t        upd;

  assign accept = start && !busy;

  // rolling window and occurrence decode for a base
  always_comb begin
    if (kmer_len_q < K_MIN) begin
      k_eff = K_MIN;
    end else if (kmer_len_q > K_MAX) begin
      k_eff = K_MAX;
    end else begin
      k_eff = kmer_len_q;
    end
    kmask = ~({IDX_W{1'b1}} << {k_eff, 1'b0});
    is_n  = req_i.base_code[2];
    if (is_n) begin
      run_d  = '0;
      roll_d = roll_q;
    end else begin
      run_d  = (run_q == '1) ? run_q : run_q + RUN_W'(1);
      roll_d = {roll_q[IDX_W-3:0], req_i.base_code[1:0]};
    end
    hit = (run_d >= RUN_W'(k_eff));

    ctx_d.is_drain = (req_i.req_type == REQ_DRAIN);
    ctx_d.idx      = ctx_d.is_drain ? req_i.drain_index : (roll_d & kmask);
    ctx_d.pos      = pos_cnt_q - POS_BITS'(k_eff - K_W'(1));
    ctx_d.k        = k_eff;

    do_rmw = ctx_d.is_drain || ((req_i.req_type == REQ_BASE) && hit);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (req_i.req_type == REQ_NEW)) begin
          state_d = ST_CLEAR;
        end else if (accept && do_rmw) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // state outputs
  always_comb begin
    busy      = 1'b1;
    tbl_re    = 1'b0;
    tbl_we    = 1'b0;
    tbl_waddr = ctx_q.idx;
    tbl_wdata = upd.entry;
    case (state_q)
      ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_q;
        tbl_wdata = '0;
      end
      ST_IDLE: begin
        busy   = 1'b0;
        tbl_re = start && do_rmw;
      end
      ST_EXEC: begin
        tbl_we = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == ST_EXEC) && upd.emit;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_q    <= '0;
      run_q     <= '0;
      pos_cnt_q <= '0;
    end else if (accept && (req_i.req_type == REQ_NEW)) begin
      roll_q    <= '0;
      run_q     <= '0;
      pos_cnt_q <= '0;
    end else if (accept && (req_i.req_type == REQ_BASE)) begin
      roll_q    <= roll_d;
      run_q     <= run_d;
      pos_cnt_q <= pos_cnt_q + POS_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q    <= KMER_LEN_RST;
      min_repeats_q <= MIN_REPEAT_RST;
      max_gap_q     <= MAX_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KMER_LEN:    kmer_len_q    <= cfg_data_i[K_W-1:0];
        CFG_MIN_REPEATS: min_repeats_q <= cfg_data_i[MINR_W-1:0];
        CFG_MAX_GAP:     max_gap_q     <= cfg_data_i[MAXG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_re) begin
      ctx_q <= ctx_d;
    end
    if (state_q == ST_EXEC) begin
      res_q <= upd.res;
    end
  end

  ktrt_table u_table (
    .clk_i     (clk_i),
    .rd_en_i   (tbl_re),
    .rd_addr_i (ctx_d.idx),
    .rd_data_o (tbl_rdata),
    .wr_en_i   (tbl_we),
    .wr_addr_i (tbl_waddr),
    .wr_data_i (tbl_wdata)
  );

  ktrt_update u_update (
    .ctx_i         (ctx_q),
    .entry_i       (tbl_rdata),
    .min_repeats_i (min_repeats_q),
    .max_gap_i     (max_gap_q),
    .upd_o         (upd)
  );

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // a result only follows a read-modify-write cycle
  a_res_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q == ST_EXEC))
    else $error("result without a table update");

  // the table is never written while transactions are being taken
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> (state_q != ST_IDLE))
    else $error("table write while idle");

  // a new sequence always starts a clearing pass
  a_new_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.req_type == REQ_NEW)) |=> (state_q == ST_CLEAR && clr_q == '0))
    else $error("new sequence did not start clearing pass");

  // an execute cycle is always preceded by a table read
  a_exec_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> $past(tbl_re))
    else $error("update without a table read");

endmodule

/* verif/ktrt_repeat_checker.sv */
// ----------------------------------------------------------------------------
// ktrt_repeat_checker
// Watches the request, configuration and result channels of the k-mer tandem
// repeat tracker, keeps its own copy of the block table and the sequence
// state, works out the repeat blocks each accepted transaction must report
// and compares every reported block field by field with the oldest one.
// ----------------------------------------------------------------------------
module ktrt_repeat_checker
  import ktrt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  ktrt_req_t             req_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  res_valid_i,
  input  ktrt_res_t             res_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // open repeat blocks, a missing key is an invalid row
  ktrt_entry_t          open_blocks [logic [IDX_W-1:0]];
  ktrt_res_t            due_blocks [$];
  logic [IDX_W-1:0]     roll_idx;
  logic [POS_BITS-1:0]  base_pos;
  logic [RUN_W-1:0]     clean_len;
  logic [K_W-1:0]       k_len;
  logic [MINR_W-1:0]    min_rep;
  logic [MAXG_W-1:0]    gap_max;
  int unsigned          fail_cnt;

  function automatic logic [K_W-1:0] window_len();
    if (k_len < K_MIN) return K_MIN;
    if (k_len > K_MAX) return K_MAX;
    return k_len;
  endfunction

  function automatic ktrt_entry_t fresh_block(logic [POS_BITS-1:0] pos, logic [K_W-1:0] k);
    ktrt_entry_t e;
    e.valid     = 1'b1;
    e.start_pos = pos;
    e.end_pos   = pos + POS_BITS'(k) - 1;
    e.count     = CNT_W'(1);
    e.gaps      = '0;
    return e;
  endfunction

  task automatic report_block(logic [IDX_W-1:0] idx, ktrt_entry_t e, logic drained);
    ktrt_res_t r;
    r.kmer_code    = idx;
    r.repeat_count = e.count;
    r.start_pos    = e.start_pos;
    r.end_pos      = e.end_pos;
    r.gap_total    = e.gaps;
    r.from_drain   = drained;
    due_blocks.push_back(r);
  endtask

  task automatic clear_sequence();
    open_blocks.delete();
    roll_idx  = '0;
    base_pos  = '0;
    clean_len = '0;
  endtask

  task automatic take_base(logic [2:0] code);
    logic [K_W-1:0]      k;
    logic [IDX_W-1:0]    kmask;
    logic [IDX_W-1:0]    idx;
    logic [POS_BITS-1:0] pos;
    logic [POS_BITS-1:0] delta;
    logic [POS_BITS:0]   lim;
    logic [POS_BITS:0]   gsum;
    ktrt_entry_t         e;
    k     = window_len();
    kmask = IDX_W'((32'd1 << (2 * k)) - 1);
    if (code > 3'd3) begin
      clean_len = '0;
    end else begin
      if (clean_len != '1) clean_len = clean_len + 1'b1;
      roll_idx = {roll_idx[IDX_W-3:0], code[1:0]};
    end
    if (clean_len >= k) begin
      idx = roll_idx & kmask;
      pos = base_pos - (POS_BITS'(k) - 1);
      if (!open_blocks.exists(idx)) begin
        open_blocks[idx] = fresh_block(pos, k);
      end else begin
        e     = open_blocks[idx];
        delta = pos - e.end_pos;
        lim   = (POS_BITS + 1)'(gap_max) + 1;
        // a window that starts at or before the block end leaves it alone
        if (!delta[POS_BITS-1] && delta != '0 && (POS_BITS + 1)'(delta) <= lim) begin
          gsum   = (POS_BITS + 1)'(e.gaps) + (POS_BITS + 1)'(delta) - 1;
          e.gaps = gsum[POS_BITS] ? '1 : gsum[GAP_W-1:0];
          if (e.count != '1) e.count = e.count + 1'b1;
          e.end_pos = pos + POS_BITS'(k) - 1;
        end else if (!delta[POS_BITS-1] && (POS_BITS + 1)'(delta) > lim) begin
          if (e.count >= min_rep) report_block(idx, e, 1'b0);
          e = fresh_block(pos, k);
        end
        open_blocks[idx] = e;
      end
    end
    base_pos = base_pos + 1'b1;
  endtask

  task automatic track_request(ktrt_req_t r);
    case (req_e'(r.req_type))
      REQ_DRAIN: begin
        if (open_blocks.exists(r.drain_index)) begin
          if (open_blocks[r.drain_index].count >= min_rep)
            report_block(r.drain_index, open_blocks[r.drain_index], 1'b1);
          open_blocks.delete(r.drain_index);
        end
      end
      REQ_NEW:  clear_sequence();
      REQ_BASE: take_base(r.base_code);
      default: ;
    endcase
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (cfg_idx_e'(idx))
      CFG_KMER_LEN:    k_len   = data[K_W-1:0];
      CFG_MIN_REPEATS: min_rep = data[MINR_W-1:0];
      CFG_MAX_GAP:     gap_max = data[MAXG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
      fail_cnt++;
    end
  endtask

  task automatic check_result(ktrt_res_t got);
    ktrt_res_t want;
    if (due_blocks.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kmer %h count %0d start %0d",
               $time, got.kmer_code, got.repeat_count, got.start_pos);
      fail_cnt++;
    end else begin
      want = due_blocks.pop_front();
      check_field("kmer_code", 32'(want.kmer_code), 32'(got.kmer_code));
      check_field("repeat_count", 32'(want.repeat_count), 32'(got.repeat_count));
      check_field("start_pos", want.start_pos, got.start_pos);
      check_field("end_pos", want.end_pos, got.end_pos);
      check_field("gap_total", want.gap_total, got.gap_total);
      check_field("from_drain", 32'(want.from_drain), 32'(got.from_drain));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_sequence();
      due_blocks.delete();
      k_len    = KMER_LEN_RST;
      min_rep  = MIN_REPEAT_RST;
      gap_max  = MAX_GAP_RST;
      fail_cnt = 0;
    end else begin
      if (cfg_we_i) write_reg(cfg_idx_i, cfg_data_i);
      if (res_valid_i) check_result(res_i);
      if (start_i && !busy_i) track_request(req_i);
    end
    pending_o    = due_blocks.size();
    fail_count_o = fail_cnt;
  end

endmodule

/* verif/tb_kmer_tandem_repeat_tracker.sv */
// ----------------------------------------------------------------------------
// tb_kmer_tandem_repeat_tracker
// Drives the tracker with a directed base stream and then phases of random
// tandem repeats, noise, drains and new sequences under several register
// settings and sender idling rates; the repeat checker beside the block
// predicts and compares the reported blocks.
// ----------------------------------------------------------------------------
module tb_kmer_tandem_repeat_tracker;
  import ktrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [2:0] BASE_A = 3'd0;
  localparam logic [2:0] BASE_C = 3'd1;
  localparam logic [2:0] BASE_G = 3'd2;
  localparam logic [2:0] BASE_T = 3'd3;
  localparam logic [2:0] BASE_N = 3'd4;
  localparam int unsigned PHASES = 7;
  localparam int unsigned PHASE_ITEMS = 170;

  typedef struct {
    logic [K_W-1:0]    k;
    logic [MINR_W-1:0] min_rep;
    logic [MAXG_W-1:0] gap;
    bit                renew;
  } phase_cfg_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  ktrt_req_t             req_i;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  res_valid_o;
  ktrt_res_t             res_o;
  int unsigned           chk_fail;
  int unsigned           chk_pending;

  int unsigned      idle_pct;
  int unsigned      n_items;
  logic [IDX_W-1:0] sent_roll;
  logic [K_W-1:0]   cur_k;
  logic [MAXG_W-1:0] cur_gap;
  phase_cfg_t       plan [PHASES];

  kmer_tandem_repeat_tracker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  ktrt_repeat_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .res_valid_i  (res_valid_o),
    .res_i        (res_o),
    .fail_count_o (chk_fail),
    .pending_o    (chk_pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #20_000_000;
    $display("timeout waiting for the tracker");
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned win_len(logic [K_W-1:0] k);
    if (k < K_MIN) return int'(K_MIN);
    if (k > K_MAX) return int'(K_MAX);
    return int'(k);
  endfunction

  function automatic ktrt_req_t mk_req(req_e t, logic [2:0] code, logic [IDX_W-1:0] idx);
    ktrt_req_t r;
    r.req_type    = t;
    r.base_code   = code;
    r.drain_index = idx;
    return r;
  endfunction

  // called at a rising edge, returns at the edge that accepts the transaction
  task automatic send_txn(ktrt_req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      req_i <= ktrt_req_t'($urandom);
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    if (r.req_type == REQ_BASE && r.base_code <= BASE_T)
      sent_roll = {sent_roll[IDX_W-3:0], r.base_code[1:0]};
    if (r.req_type == REQ_NEW) sent_roll = '0;
    if (r.req_type != REQ_NONE) n_items++;
  endtask

  task automatic send_base(logic [2:0] code);
    send_txn(mk_req(REQ_BASE, code, IDX_W'($urandom)));
  endtask

  task automatic drain_recent();
    logic [IDX_W-1:0] kmask;
    kmask = IDX_W'((32'd1 << (2 * win_len(cur_k))) - 1);
    send_txn(mk_req(REQ_DRAIN, 3'($urandom), sent_roll & kmask));
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // lets every outstanding result arrive and the block go quiet
  task automatic settle();
    int unsigned waited;
    start  <= 1'b0;
    waited = 0;
    while (chk_pending != 0 && waited < 2000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (6) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic load_phase(phase_cfg_t c);
    write_cfg(CFG_KMER_LEN, {CFG_DATA_W'($urandom) << K_W} | CFG_DATA_W'(c.k));
    write_cfg(CFG_MIN_REPEATS, c.min_rep);
    write_cfg(CFG_MAX_GAP, {CFG_DATA_W'($urandom) << MAXG_W} | CFG_DATA_W'(c.gap));
    cur_k   = c.k;
    cur_gap = c.gap;
  endtask

  task automatic tandem_burst();
    logic [1:0]  unit_code [12];
    int unsigned ulen;
    int unsigned reps;
    int unsigned gmax;
    logic [2:0]  code;
    ulen = $urandom_range(1, win_len(cur_k) + 1 + ((cur_gap > 2) ? 2 : int'(cur_gap)) + 1);
    reps = $urandom_range(2, 6);
    gmax = (cur_gap > 4) ? 6 : int'(cur_gap) + 2;
    for (int i = 0; i < ulen; i++) unit_code[i] = 2'($urandom);
    for (int rp = 0; rp < reps; rp++) begin
      for (int i = 0; i < ulen; i++) begin
        code = {1'b0, unit_code[i]};
        // a rare unknown base breaks the repeat
        if ($urandom_range(0, 99) < 3) code = 3'($urandom_range(4, 7));
        send_base(code);
      end
      if ($urandom_range(0, 99) < 20)
        repeat ($urandom_range(1, gmax)) send_base(3'($urandom_range(0, 3)));
    end
    if ($urandom_range(0, 99) < 30) drain_recent();
  endtask

  task automatic run_phase(int unsigned target);
    int unsigned sel;
    while (n_items < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        tandem_burst();
      end else if (sel < 82) begin
        repeat ($urandom_range(1, 6)) send_base(3'($urandom));
      end else if (sel < 95) begin
        if ($urandom_range(0, 99) < 60) drain_recent();
        else send_txn(mk_req(REQ_DRAIN, 3'($urandom), IDX_W'($urandom)));
      end else begin
        send_txn(mk_req(REQ_NONE, 3'($urandom), IDX_W'($urandom)));
      end
    end
  endtask

  initial begin
    plan[0] = '{k: 4'd2,  min_rep: 16'd1,     gap: 8'd0,   renew: 1'b0};
    plan[1] = '{k: 4'd8,  min_rep: 16'd3,     gap: 8'd255, renew: 1'b1};
    plan[2] = '{k: 4'd3,  min_rep: 16'd2,     gap: 8'd4,   renew: 1'b0};
    plan[3] = '{k: 4'd15, min_rep: 16'd65535, gap: 8'd1,   renew: 1'b0};
    plan[4] = '{k: 4'd0,  min_rep: 16'd0,     gap: 8'd2,   renew: 1'b1};
    plan[5] = '{k: 4'd5,  min_rep: 16'd4,     gap: 8'd1,   renew: 1'b0};
    plan[6] = '{k: 4'd1,  min_rep: 16'd2,     gap: 8'd0,   renew: 1'b1};

    rst_ni     <= 1'b0;
    start      <= 1'b0;
    req_i      <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    idle_pct   = 8;
    n_items    = 0;
    sent_roll  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // directed: short repeats, unknown bases, drains, ignored and new sequence
    write_cfg(CFG_SPARE, 16'hFFFF);
    load_phase('{k: 4'd2, min_rep: 16'd2, gap: 8'd1, renew: 1'b0});
    send_base(BASE_A); send_base(BASE_C); send_base(BASE_A);
    send_base(BASE_C); send_base(BASE_A); send_base(BASE_C);
    // overlapping windows, then a far occurrence closes the AC block
    send_base(BASE_T); send_base(BASE_T); send_base(BASE_T);
    send_base(BASE_A); send_base(BASE_C);
    send_base(3'd5); send_base(3'd6); send_base(3'd7); send_base(BASE_N);
    send_base(BASE_G); send_base(BASE_T); send_base(BASE_G); send_base(BASE_T);
    send_txn(mk_req(REQ_DRAIN, 3'd7, 16'h0001));
    send_txn(mk_req(REQ_DRAIN, 3'd0, 16'h000B));
    send_txn(mk_req(REQ_DRAIN, 3'd5, 16'hFFFF));
    send_txn(mk_req(REQ_NONE, 3'd7, 16'hFFFF));
    send_txn(mk_req(REQ_NEW, 3'($urandom), IDX_W'($urandom)));
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 3)
        0:       idle_pct = 8;
        1:       idle_pct = 54;
        default: idle_pct = 0;
      endcase
      load_phase(plan[p]);
      if (plan[p].renew) send_txn(mk_req(REQ_NEW, 3'($urandom), IDX_W'($urandom)));
      run_phase(n_items + PHASE_ITEMS);
      settle();
    end

    if (chk_pending != 0) $display("%0d expected results never arrived", chk_pending);
    if (chk_fail == 0 && chk_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* kmer_tandem_repeat_tracker.f */
rtl/ktrt_pkg.sv
rtl/ktrt_table.sv
rtl/ktrt_update.sv
rtl/kmer_tandem_repeat_tracker.sv
verif/ktrt_repeat_checker.sv
verif/tb_kmer_tandem_repeat_tracker.sv
